// ===== rtl/core/mrop_pkg.sv =====
`default_nettype none

package mrop_pkg;

    // field widths
    localparam int ELAPSED_W  = 16;
    localparam int TARGET_W   = 16;
    localparam int SAMPLE_W   = 12;
    localparam int ACCEL_W    = 16;
    localparam int LIMIT_W    = 12;
    localparam int DUTY_W     = 12;
    localparam int POWER_W    = 13;
    localparam int AGE_W      = 16;
    localparam int RAMP_W     = 28;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 40;

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LOW  = 2'd2;

    localparam logic [ACCEL_W-1:0] ACCEL_RESET      = 16'd1000;
    localparam logic [LIMIT_W-1:0] LIMIT_HIGH_RESET = 12'd4095;
    localparam logic [LIMIT_W-1:0] LIMIT_LOW_RESET  = 12'd0;

    // fixed point and output scaling
    localparam int FRACTION_BITS = 10;
    localparam int POWER_CLAMP   = 2500;
    localparam logic [DUTY_W-1:0] PWM_PERIOD = 12'd3200;

    // timing
    localparam logic [AGE_W-1:0] AGE_MAX         = 16'hFFFF;
    localparam logic [AGE_W-1:0] HEALTH_LIMIT_MS = 16'd1000;
    localparam logic [AGE_W-1:0] HOLD_MS         = 16'd1000;
    localparam int               MS_PER_S        = 1000;

    // step = floor(accel*dt*2^FRACTION_BITS/1000), split as
    // 1024*floor(x/1000) + floor((x%1000)*128/125)
    localparam int PROD_W         = ACCEL_W + ELAPSED_W;
    localparam int Q_W            = 23;
    localparam int REM_W          = 10;
    localparam int DIV_PRE_SHIFT  = 3;
    localparam int RECIP_MS_W     = 30;
    localparam logic [RECIP_MS_W-1:0] RECIP_MS = 30'd549755814;  // ceil(2^36/125)
    localparam int RECIP_MS_SHIFT = 36;
    localparam int FRAC_N_W       = 17;
    localparam int FRAC_RECIP_W   = 18;
    localparam logic [FRAC_RECIP_W-1:0] FRAC_RECIP = 18'd134218;  // ceil(2^24/125)
    localparam int FRAC_SHIFT     = 24;
    localparam int STEP_W         = Q_W + FRACTION_BITS;

    // three-sample average
    localparam int SUM_W        = 14;
    localparam int RECIP3_W     = 15;
    localparam logic [RECIP3_W-1:0] RECIP3 = 15'd21846;  // ceil(2^16/3)
    localparam int RECIP3_SHIFT = 16;

    typedef struct packed {
        logic                      protection_active;
        logic signed [POWER_W-1:0] power_applied;
        logic [DUTY_W-1:0]         duty_reverse;
        logic [DUTY_W-1:0]         duty_forward;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/mrop_duty.sv =====
`default_nettype none

// Ramped fixed-point power -> clamped integer power and bridge duties.
module mrop_duty (
    input  wire logic signed [mrop_pkg::RAMP_W-1:0] ramped_power,
    input  wire logic                               hold,
    output mrop_pkg::result_t                       result
);
    import mrop_pkg::*;

    localparam logic signed [RAMP_W-1:0] CLAMP_POS = RAMP_W'(POWER_CLAMP);
    localparam logic signed [RAMP_W-1:0] CLAMP_NEG = -CLAMP_POS;
    localparam logic signed [RAMP_W-1:0] ROUND_BIAS = RAMP_W'((1 << FRACTION_BITS) - 1);

    logic signed [RAMP_W-1:0] biased;
    logic signed [RAMP_W-1:0] p_trunc;
    logic signed [RAMP_W-1:0] p_clamped;
    logic signed [RAMP_W-1:0] p_abs;
    logic [DUTY_W-1:0]        mag;
    logic [DUTY_W-1:0]        duty_active;

    always_comb begin
        // truncate toward zero
        biased  = ramped_power[RAMP_W-1] ? ramped_power + ROUND_BIAS : ramped_power;
        p_trunc = biased >>> FRACTION_BITS;

        if (p_trunc > CLAMP_POS) begin
            p_clamped = CLAMP_POS;
        end else if (p_trunc < CLAMP_NEG) begin
            p_clamped = CLAMP_NEG;
        end else begin
            p_clamped = p_trunc;
        end

        p_abs = p_clamped[RAMP_W-1] ? -p_clamped : p_clamped;
        mag   = p_abs[DUTY_W-1:0];

        duty_active = (mag >= PWM_PERIOD) ? '0 : PWM_PERIOD - mag;

        result.protection_active = hold;
        result.power_applied     = p_clamped[POWER_W-1:0];
        result.duty_forward      = (p_clamped > 0) ? duty_active : PWM_PERIOD;
        result.duty_reverse      = (p_clamped < 0) ? duty_active : PWM_PERIOD;
    end

endmodule

`default_nettype wire

// ===== rtl/core/motor_ramp_overcurrent_pwm.sv =====
`default_nettype none

// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+----------------------------------------------
// s_       | in  | s_tvalid/s_tready  | s_tdata: elapsed_ms, power_target, sample
// m_       | out | m_tvalid/m_tready  | m_tdata: duties, power_applied; m_tuser: prot
// cfg_     | in  | cfg_we             | cfg_addr, cfg_wdata
//
// Throughput: one word per cycle while m_ is not stalled. A word accepted on
// s_ passes through S0..S5 and the result register to m_. The depth is set by
// the ramp step's divide by 1000, spread over product, quotient, remainder and
// fraction stages ahead of the state stage; ramp, ages and hold update together.
// Reset: synchronous, active low; clears valids, sets state and config to reset values.
// Stalls: every stage holds when its successor is full and held; s_tready stays high
// while any stage ahead has room, so input keeps flowing behind a stalled m_.
module motor_ramp_overcurrent_pwm (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [15:0] elapsed_ms, [31:16] power_target, [43:32] current_sample
    input  wire logic [mrop_pkg::S_TDATA_W-1:0]      s_tdata,

    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [11:0] duty_forward, [23:12] duty_reverse, [36:24] power_applied
    output logic [mrop_pkg::M_TDATA_W-1:0]           m_tdata,
    // [0] protection_active
    output logic                                     m_tuser,

    input  wire logic                                cfg_we,
    input  wire logic [mrop_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [mrop_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import mrop_pkg::*;

    localparam int QMUL_W = (PROD_W - DIV_PRE_SHIFT) + RECIP_MS_W;
    localparam int FMUL_W = FRAC_N_W + FRAC_RECIP_W;
    localparam int AMUL_W = SUM_W + RECIP3_W;
    localparam int PIPE_N = 7;  // S0..S5 plus the result register

    // ---------------------------------------------------------------
    // config registers
    // ---------------------------------------------------------------
    logic [ACCEL_W-1:0] accel_rate_reg;
    logic [LIMIT_W-1:0] current_high_reg;
    logic [LIMIT_W-1:0] current_low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_rate_reg   <= ACCEL_RESET;
            current_high_reg <= LIMIT_HIGH_RESET;
            current_low_reg  <= LIMIT_LOW_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ACCEL_RATE:   accel_rate_reg   <= cfg_wdata[ACCEL_W-1:0];
                REG_CURRENT_HIGH: current_high_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_CURRENT_LOW:  current_low_reg  <= cfg_wdata[LIMIT_W-1:0];
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stage valids and advance chain
    // adv[k]: stage k hands its word to stage k+1 this cycle
    // ---------------------------------------------------------------
    logic [PIPE_N-1:0] valid_reg;
    logic [PIPE_N-1:0] adv;
    logic              in_acc;

    always_comb begin
        adv[6] = valid_reg[6] && m_tready;
        adv[5] = valid_reg[5] && (!valid_reg[6] || adv[6]);
        adv[4] = valid_reg[4] && (!valid_reg[5] || adv[5]);
        adv[3] = valid_reg[3] && (!valid_reg[4] || adv[4]);
        adv[2] = valid_reg[2] && (!valid_reg[3] || adv[3]);
        adv[1] = valid_reg[1] && (!valid_reg[2] || adv[2]);
        adv[0] = valid_reg[0] && (!valid_reg[1] || adv[1]);
    end

    assign s_tready = !valid_reg[0] || adv[0];
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg[0] <= in_acc ? 1'b1 : (adv[0] ? 1'b0 : valid_reg[0]);
            valid_reg[1] <= adv[0] ? 1'b1 : (adv[1] ? 1'b0 : valid_reg[1]);
            valid_reg[2] <= adv[1] ? 1'b1 : (adv[2] ? 1'b0 : valid_reg[2]);
            valid_reg[3] <= adv[2] ? 1'b1 : (adv[3] ? 1'b0 : valid_reg[3]);
            valid_reg[4] <= adv[3] ? 1'b1 : (adv[4] ? 1'b0 : valid_reg[4]);
            valid_reg[5] <= adv[4] ? 1'b1 : (adv[5] ? 1'b0 : valid_reg[5]);
            valid_reg[6] <= adv[5] ? 1'b1 : (adv[6] ? 1'b0 : valid_reg[6]);
        end
    end

    // ---------------------------------------------------------------
    // S0: input register
    // ---------------------------------------------------------------
    logic [ELAPSED_W-1:0]       s0_dt_reg;
    logic signed [TARGET_W-1:0] s0_target_reg;
    logic [SAMPLE_W-1:0]        s0_sample_reg;

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            s0_dt_reg     <= s_tdata[15:0];
            s0_target_reg <= s_tdata[31:16];
            s0_sample_reg <= s_tdata[43:32];
        end
    end

    // ---------------------------------------------------------------
    // S1: accel*dt, three-sample sum; sample history shifts here
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0]        hist0_reg;
    logic [SAMPLE_W-1:0]        hist1_reg;
    logic [PROD_W-1:0]          s1_prod_reg;
    logic [SUM_W-1:0]           s1_sum_reg;
    logic [ELAPSED_W-1:0]       s1_dt_reg;
    logic signed [TARGET_W-1:0] s1_target_reg;
    logic [PROD_W-1:0]          prod_c;
    logic [SUM_W-1:0]           sum_c;

    assign prod_c = {{(PROD_W-ACCEL_W){1'b0}}, accel_rate_reg}
                  * {{(PROD_W-ELAPSED_W){1'b0}}, s0_dt_reg};
    assign sum_c  = {{(SUM_W-SAMPLE_W){1'b0}}, s0_sample_reg}
                  + {{(SUM_W-SAMPLE_W){1'b0}}, hist0_reg}
                  + {{(SUM_W-SAMPLE_W){1'b0}}, hist1_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist0_reg <= '0;
            hist1_reg <= '0;
        end else if (adv[0]) begin
            hist0_reg <= s0_sample_reg;
            hist1_reg <= hist0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s1_prod_reg   <= prod_c;
            s1_sum_reg    <= sum_c;
            s1_dt_reg     <= s0_dt_reg;
            s1_target_reg <= s0_target_reg;
        end
    end

    // ---------------------------------------------------------------
    // S2: quotient by 1000, average by 3 (reciprocal multiplies)
    // ---------------------------------------------------------------
    logic [Q_W-1:0]             s2_q_reg;
    logic [PROD_W-1:0]          s2_prod_reg;
    logic [SAMPLE_W-1:0]        s2_avg_reg;
    logic [ELAPSED_W-1:0]       s2_dt_reg;
    logic signed [TARGET_W-1:0] s2_target_reg;
    logic [QMUL_W-1:0]          qmul_c;
    logic [AMUL_W-1:0]          amul_c;

    assign qmul_c = {{RECIP_MS_W{1'b0}}, s1_prod_reg[PROD_W-1:DIV_PRE_SHIFT]}
                  * {{(QMUL_W-RECIP_MS_W){1'b0}}, RECIP_MS};
    assign amul_c = {{RECIP3_W{1'b0}}, s1_sum_reg}
                  * {{(AMUL_W-RECIP3_W){1'b0}}, RECIP3};

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s2_q_reg      <= qmul_c[RECIP_MS_SHIFT +: Q_W];
            s2_avg_reg    <= amul_c[RECIP3_SHIFT +: SAMPLE_W];
            s2_prod_reg   <= s1_prod_reg;
            s2_dt_reg     <= s1_dt_reg;
            s2_target_reg <= s1_target_reg;
        end
    end

    // ---------------------------------------------------------------
    // S3: remainder mod 1000, health compare
    // ---------------------------------------------------------------
    logic [Q_W-1:0]             s3_q_reg;
    logic [REM_W-1:0]           s3_rem_reg;
    logic                       s3_healthy_reg;
    logic [ELAPSED_W-1:0]       s3_dt_reg;
    logic signed [TARGET_W-1:0] s3_target_reg;
    logic [PROD_W-1:0]          rem_full_c;

    assign rem_full_c = s2_prod_reg
                      - ({{(PROD_W-Q_W){1'b0}}, s2_q_reg} * PROD_W'(MS_PER_S));

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            s3_q_reg       <= s2_q_reg;
            s3_rem_reg     <= rem_full_c[REM_W-1:0];
            s3_healthy_reg <= (s2_avg_reg < current_high_reg)
                           && (s2_avg_reg > current_low_reg);
            s3_dt_reg      <= s2_dt_reg;
            s3_target_reg  <= s2_target_reg;
        end
    end

    // ---------------------------------------------------------------
    // S4: fraction bits of the step, step assembled
    // ---------------------------------------------------------------
    logic [STEP_W-1:0]          s4_step_reg;
    logic                       s4_healthy_reg;
    logic [ELAPSED_W-1:0]       s4_dt_reg;
    logic signed [TARGET_W-1:0] s4_target_reg;
    logic [FMUL_W-1:0]          fmul_c;

    // rem*128 times ceil(2^24/125)
    assign fmul_c = {{FRAC_RECIP_W{1'b0}}, s3_rem_reg, {(FRAC_N_W-REM_W){1'b0}}}
                  * {{FRAC_N_W{1'b0}}, FRAC_RECIP};

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            s4_step_reg    <= {s3_q_reg, fmul_c[FRAC_SHIFT +: FRACTION_BITS]};
            s4_healthy_reg <= s3_healthy_reg;
            s4_dt_reg      <= s3_dt_reg;
            s4_target_reg  <= s3_target_reg;
        end
    end

    // ---------------------------------------------------------------
    // S5: state update (ramp, ages, hold)
    // ---------------------------------------------------------------
    logic signed [RAMP_W-1:0] ramped_power_reg;
    logic [AGE_W-1:0]         unhealthy_age_reg;
    logic [AGE_W-1:0]         trip_age_reg;
    logic signed [RAMP_W-1:0] s5_power_reg;
    logic                     s5_hold_reg;

    logic signed [RAMP_W-1:0] target_fx;
    logic                     ramp_up;
    logic                     ramp_down;
    logic signed [RAMP_W-1:0] gap_s;
    logic [STEP_W-1:0]        gap_ext;
    logic signed [RAMP_W-1:0] step_s;
    logic signed [RAMP_W-1:0] moved;
    logic signed [RAMP_W-1:0] ramp_c;
    logic signed [RAMP_W-1:0] ramp_next;
    logic [AGE_W:0]           unh_sum;
    logic [AGE_W:0]           trip_sum;
    logic [AGE_W-1:0]         unh_next;
    logic [AGE_W-1:0]         trip_adv;
    logic [AGE_W-1:0]         trip_next;
    logic                     hold_c;

    always_comb begin
        target_fx = {{(RAMP_W-TARGET_W-FRACTION_BITS){s4_target_reg[TARGET_W-1]}},
                     s4_target_reg, {FRACTION_BITS{1'b0}}};
        ramp_up   = ramped_power_reg < target_fx;
        ramp_down = ramped_power_reg > target_fx;
        gap_s     = ramp_up ? target_fx - ramped_power_reg : ramped_power_reg - target_fx;
        gap_ext   = {{(STEP_W-RAMP_W){1'b0}}, gap_s};
        // below the gap the step fits the ramp width
        step_s    = s4_step_reg[RAMP_W-1:0];
        moved     = ramp_up ? ramped_power_reg + step_s : ramped_power_reg - step_s;

        if ((s4_dt_reg == '0) || !(ramp_up || ramp_down)) begin
            ramp_c = ramped_power_reg;
        end else if (s4_step_reg >= gap_ext) begin
            ramp_c = target_fx;
        end else begin
            ramp_c = moved;
        end

        unh_sum  = {1'b0, unhealthy_age_reg} + {1'b0, s4_dt_reg};
        trip_sum = {1'b0, trip_age_reg} + {1'b0, s4_dt_reg};
        if (s4_healthy_reg) begin
            unh_next = '0;
        end else begin
            unh_next = unh_sum[AGE_W] ? AGE_MAX : unh_sum[AGE_W-1:0];
        end
        trip_adv  = trip_sum[AGE_W] ? AGE_MAX : trip_sum[AGE_W-1:0];
        trip_next = (unh_next > HEALTH_LIMIT_MS) ? '0 : trip_adv;
        hold_c    = trip_next < HOLD_MS;
        ramp_next = hold_c ? '0 : ramp_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramped_power_reg  <= '0;
            unhealthy_age_reg <= '0;
            trip_age_reg      <= AGE_MAX;
        end else if (adv[4]) begin
            ramped_power_reg  <= ramp_next;
            unhealthy_age_reg <= unh_next;
            trip_age_reg      <= trip_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            s5_power_reg <= ramp_next;
            s5_hold_reg  <= hold_c;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    result_t res_c;
    result_t res_reg;

    mrop_duty u_duty (
        .ramped_power (s5_power_reg),
        .hold         (s5_hold_reg),
        .result       (res_c)
    );

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            res_reg <= res_c;
        end
    end

    assign m_tvalid = valid_reg[6];
    assign m_tdata  = {{(M_TDATA_W-POWER_W-2*DUTY_W){1'b0}},
                       res_reg.power_applied, res_reg.duty_reverse, res_reg.duty_forward};
    assign m_tuser  = res_reg.protection_active;

`ifndef NO_ASSERTIONS
    // a trip always restarts the hold timer
    a_trip_on_long_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        (unhealthy_age_reg > HEALTH_LIMIT_MS) |-> (trip_age_reg == '0))
        else $error("unhealthy past limit without trip");

    // while held, the bridge is idle
    a_hold_idles_bridge: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.protection_active) |->
            (res_reg.power_applied == '0 && res_reg.duty_forward == PWM_PERIOD
             && res_reg.duty_reverse == PWM_PERIOD))
        else $error("power driven during overcurrent hold");

    // never both legs active
    a_one_leg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_reg.duty_forward == PWM_PERIOD
                      || res_reg.duty_reverse == PWM_PERIOD))
        else $error("both bridge legs active");

    // ramp stays inside the span of representable targets
    a_ramp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ramped_power_reg >= -(RAMP_W'(1) <<< (TARGET_W + FRACTION_BITS - 1)))
        && (ramped_power_reg <= ((RAMP_W'(1) <<< (TARGET_W + FRACTION_BITS - 1))
                                 - (RAMP_W'(1) <<< FRACTION_BITS))))
        else $error("ramped power out of target range");
`endif

endmodule

`default_nettype wire
